>>> hw/rtl/wpm_pkg.sv
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// no dependencies; imported by wildcard_pattern_matcher
`default_nettype none
package wpm_pkg;

  localparam int unsigned MAX_PATTERN_DEF   = 8;
  localparam int unsigned POSITION_BITS_DEF = 32;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned HIT_W       = 32;

  localparam logic [7:0] WILDCARD = 8'h3F;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_index_e;

endpackage
`default_nettype wire

>>> hw/rtl/wildcard_pattern_matcher.sv
// wildcard_pattern_matcher: streaming search of text bytes for a pattern with '?' wildcards
// depends on wpm_pkg
// Takes one text byte per cycle and reports every 0-based start position at which
// the configured pattern (up to MAX_PATTERN bytes, '?' matches any byte) ends in the
// window of the most recent bytes. Each new byte is shifted into the window and all
// candidate alignments are compared in parallel against the pattern in the same cycle,
// the hit going into an output register that is seen on the next cycle. Throughput is
// one item per cycle; input is held off only while that output register is full and
// stalled. A byte flagged as text end is still searched, then the window, fill count
// and position counter clear. The position counter saturates at its maximum. Configuration
// must be written only while the block is idle; the block itself does not enforce this.
`default_nettype none
module wildcard_pattern_matcher #(
  parameter int unsigned MAX_PATTERN   = wpm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = wpm_pkg::POSITION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wpm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [wpm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     text_byte_i,
  input  wire logic                           text_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [wpm_pkg::HIT_W-1:0]           hit_position_o
);
  import wpm_pkg::*;

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_PATTERN);

  logic [CFG_DATA_W-1:0]    pattern_q;
  logic [LEN_W-1:0]         length_q;
  logic [7:0]               win_q [MAX_PATTERN];
  logic [7:0]               win_d [MAX_PATTERN];
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     out_valid_q;
  logic [HIT_W-1:0]         hit_q;

  logic                     in_acc;
  logic [LEN_W-1:0]         len_used;
  logic [LEN_W-1:0]         len_m1;
  logic [MAX_PATTERN-1:0]   match_len;
  logic                     hit_c;
  logic [POSITION_BITS-1:0] start_pos;

  assign in_stall_o     = out_valid_q & out_stall_i;
  assign in_acc         = in_valid_i & ~in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign hit_position_o = hit_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_PATTERN_BYTES:  pattern_q <= cfg_wdata_i;
        CFG_PATTERN_LENGTH: length_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to 1..MAX_PATTERN
  always_comb begin
    if (length_q == '0) begin
      len_used = LEN_W'(1);
    end else if (length_q > LEN_MAX) begin
      len_used = LEN_MAX;
    end else begin
      len_used = length_q;
    end
  end
  assign len_m1 = len_used - LEN_W'(1);

  // window shift, newest byte at entry 0
  always_comb begin
    win_d[0] = text_byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign fill_d = (fill_q == FILL_MAX) ? fill_q : fill_q + FILL_W'(1);
  assign pos_d  = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);

  // match for each candidate length in parallel
  always_comb begin
    for (int l = 0; l < MAX_PATTERN; l++) begin
      match_len[l] = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (i <= l) begin
          if (pattern_q[8*i +: 8] != WILDCARD && pattern_q[8*i +: 8] != win_d[l-i]) begin
            match_len[l] = 1'b0;
          end
        end
      end
    end
  end

  assign hit_c     = (LEN_W'(fill_d) >= len_used) & match_len[len_m1[IDX_W-1:0]];
  assign start_pos = pos_q - POSITION_BITS'(len_m1);

  // text state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= '0;
      end
    end else if (in_acc) begin
      if (text_end_i) begin
        fill_q <= '0;
        pos_q  <= '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          win_q[k] <= '0;
        end
      end else begin
        fill_q <= fill_d;
        pos_q  <= pos_d;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          win_q[k] <= win_d[k];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_acc & hit_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hit_c) begin
      hit_q <= HIT_W'(start_pos);
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("window fill above pattern capacity");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && text_end_i |=> fill_q == '0 && pos_q == '0)
    else $error("text end did not clear state");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !text_end_i && pos_q != '1 |=> pos_q == $past(pos_q) + POSITION_BITS'(1))
    else $error("position counter did not advance");

  a_hit_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && hit_c |-> LEN_W'(fill_d) >= len_used && pos_q >= POSITION_BITS'(len_m1))
    else $error("hit before window holds the pattern");

  a_hit_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && hit_c |=> out_valid_o && hit_q == $past(HIT_W'(start_pos)))
    else $error("hit not presented");

endmodule
`default_nettype wire
